>>> sv/dfts_pkg.sv
// shared types, constants and character helpers for the decimal float text scanner
package dfts_pkg;

    localparam int MAX_DIGITS   = 20;
    localparam int LENGTH_BITS  = 16;
    localparam int COUNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int OUT_LEN_W    = 16;
    localparam int ACC_W        = 20;
    localparam int SHIFT_W      = 21;
    localparam int EXP_W        = 22;
    localparam int BCD_W        = 40;

    localparam logic [ACC_W-1:0]          ACC_LIMIT = ACC_W'(999999);
    localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(999999);
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = -SHIFT_W'(999999);
    localparam logic [LENGTH_BITS-1:0]    LEN_MAX   = {LENGTH_BITS{1'b1}};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_LO_N  = 8'h6e;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_Y  = 8'h79;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SPACE,
        PH_NAN,
        PH_SIGNED,
        PH_INF,
        PH_INT,
        PH_FRAC,
        PH_EXPMARK,
        PH_EXPSIGN,
        PH_EXPDIG
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NUMBER,
        KIND_INF,
        KIND_NAN
    } t_kind;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] nan_letter(input logic [1:0] idx);
        logic [7:0] l;
        unique case (idx)
            2'd1:    l = CH_LO_A;
            default: l = CH_LO_N;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] inf_letter(input logic [2:0] idx);
        logic [7:0] l;
        unique case (idx)
            3'd0:    l = CH_LO_I;
            3'd1:    l = CH_LO_N;
            3'd2:    l = CH_LO_F;
            3'd3:    l = CH_LO_I;
            3'd4:    l = CH_LO_N;
            3'd5:    l = CH_LO_I;
            3'd6:    l = CH_LO_T;
            default: l = CH_LO_Y;
        endcase
        return l;
    endfunction

endpackage

>>> sv/decimal_float_text_scanner.sv
// Decimal float text scanner: one text byte per item in, one token summary per finished token out.
// The block takes one byte per clock and reports a token from the result register: the byte that
// ends it passes an input register, then the scan-state update that loads the result. Throughput is
// one byte per cycle as long as the result side takes results; the only loop is the scan-state
// update. A result that is not taken holds the scan, so the input takes at most one more byte
// and then stalls until the result leaves. Up to MAX_DIGITS significant digits are
// kept as BCD; the decimal exponent already includes the shift from fraction digits and digits
// dropped past the limit.
module decimal_float_text_scanner
    import dfts_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_starts_string,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_negative,
    output logic [1:0]                     o_number_kind,
    output logic [4:0]                     o_digit_count,
    output logic [BCD_W-1:0]               o_digits_first_ten,
    output logic [BCD_W-1:0]               o_digits_last_ten,
    output logic signed [EXP_W-1:0]        o_decimal_exponent,
    output logic [OUT_LEN_W-1:0]           o_consumed_length
);

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_start;

    // scan state
    t_phase                     r_phase,   n_phase,   c_phase;
    logic [2:0]                 r_kp,      n_kp,      c_kp;
    logic                       r_sign,    n_sign,    c_sign;
    t_kind                      r_kind,    n_kind,    c_kind;
    logic [3:0]                 r_digits [MAX_DIGITS];
    logic [3:0]                 n_digits [MAX_DIGITS];
    logic [3:0]                 c_digits [MAX_DIGITS];
    logic [COUNT_W-1:0]         r_count,   n_count,   c_count;
    logic signed [SHIFT_W-1:0]  r_ps,      n_ps,      c_ps;
    logic [ACC_W-1:0]           r_acc,     n_acc,     c_acc;
    logic                       r_expneg,  n_expneg,  c_expneg;
    logic [LENGTH_BITS-1:0]     r_len,     n_len,     c_len;

    // result register
    logic                       r_out_valid;
    logic                       r_out_neg;
    t_kind                      r_out_kind;
    logic [4:0]                 r_out_count;
    logic [BCD_W-1:0]           r_out_first;
    logic [BCD_W-1:0]           r_out_last;
    logic signed [EXP_W-1:0]    r_out_exp;
    logic [OUT_LEN_W-1:0]       r_out_len;

    // decisions from the state logic
    logic       proc;
    logic       emit;
    t_kind      fin_kind;
    logic [2:0] fin_trim;

    // result fields
    logic                       res_neg;
    logic [4:0]                 res_count;
    logic [BCD_W-1:0]           res_first;
    logic [BCD_W-1:0]           res_last;
    logic signed [EXP_W-1:0]    res_exp;
    logic [OUT_LEN_W-1:0]       res_len;

    logic [7:0] ch;
    logic [7:0] lc;
    logic [3:0] dval;
    logic       dig;

    assign proc    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_char  <= i_char_code;
            r_s1_start <= i_starts_string;
        end
    end

    // a start byte abandons the scan in progress
    always_comb begin
        c_phase  = r_s1_start ? PH_SPACE : r_phase;
        c_kp     = r_s1_start ? 3'd0 : r_kp;
        c_sign   = r_s1_start ? 1'b0 : r_sign;
        c_kind   = r_s1_start ? KIND_NONE : r_kind;
        c_count  = r_s1_start ? '0 : r_count;
        c_ps     = r_s1_start ? '0 : r_ps;
        c_acc    = r_s1_start ? '0 : r_acc;
        c_expneg = r_s1_start ? 1'b0 : r_expneg;
        c_len    = r_s1_start ? '0 : r_len;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            c_digits[i] = r_s1_start ? 4'd0 : r_digits[i];
        end
    end

    assign ch   = r_s1_char;
    assign lc   = to_lower(r_s1_char);
    assign dval = r_s1_char[3:0];
    assign dig  = is_digit(r_s1_char);

    // next state
    always_comb begin
        logic fall_signed;
        logic fall_expdig;
        logic do_int;
        logic do_frac;
        logic do_exp;
        logic do_consume;
        logic [ACC_W+3:0] acc10;

        n_phase  = c_phase;
        n_kp     = c_kp;
        n_sign   = c_sign;
        n_kind   = c_kind;
        n_count  = c_count;
        n_ps     = c_ps;
        n_acc    = c_acc;
        n_expneg = c_expneg;
        n_len    = c_len;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            n_digits[i] = c_digits[i];
        end
        emit        = 1'b0;
        fin_kind    = KIND_NONE;
        fin_trim    = 3'd0;
        fall_signed = 1'b0;
        fall_expdig = 1'b0;
        do_int      = 1'b0;
        do_frac     = 1'b0;
        do_exp      = 1'b0;
        do_consume  = 1'b0;
        acc10       = '0;

        unique case (c_phase)
            PH_IDLE: begin
            end
            PH_SPACE: begin
                if (is_space(ch)) begin
                    do_consume = 1'b1;
                end else if (lc == CH_LO_N) begin
                    n_phase    = PH_NAN;
                    n_kp       = 3'd0;
                    do_consume = 1'b1;
                end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                    n_sign     = (ch == CH_MINUS);
                    n_phase    = PH_SIGNED;
                    do_consume = 1'b1;
                end else begin
                    fall_signed = 1'b1;
                end
            end
            PH_SIGNED: begin
                fall_signed = 1'b1;
            end
            PH_NAN: begin
                if (c_kp >= 3'd2) begin
                    emit     = 1'b1;
                    fin_kind = KIND_NAN;
                end else if (lc == nan_letter(c_kp[1:0] + 2'd1)) begin
                    n_kp       = c_kp + 3'd1;
                    do_consume = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_INF: begin
                if (c_kp == 3'd7) begin
                    emit     = 1'b1;
                    fin_kind = KIND_INF;
                end else if (lc == inf_letter(c_kp + 3'd1)) begin
                    n_kp       = c_kp + 3'd1;
                    do_consume = 1'b1;
                end else if (c_kp >= 3'd2) begin
                    // partial "infinity" falls back to plain "inf"
                    emit     = 1'b1;
                    fin_kind = KIND_INF;
                    fin_trim = c_kp - 3'd2;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_INT, PH_FRAC: begin
                if (dig) begin
                    do_int     = (c_phase == PH_INT);
                    do_frac    = (c_phase == PH_FRAC);
                    do_consume = 1'b1;
                end else if (ch == CH_POINT && c_phase == PH_INT) begin
                    n_phase    = PH_FRAC;
                    do_consume = 1'b1;
                end else if (lc == CH_LO_E && c_kind == KIND_NUMBER) begin
                    n_phase    = PH_EXPMARK;
                    do_consume = 1'b1;
                end else begin
                    emit     = 1'b1;
                    fin_kind = c_kind;
                end
            end
            PH_EXPMARK: begin
                if (ch == CH_PLUS || ch == CH_MINUS) begin
                    n_expneg   = (ch == CH_MINUS);
                    n_phase    = PH_EXPSIGN;
                    do_consume = 1'b1;
                end else if (!dig) begin
                    emit     = 1'b1;
                    fin_kind = c_kind;
                    fin_trim = 3'd1;
                end else begin
                    fall_expdig = 1'b1;
                end
            end
            PH_EXPSIGN: begin
                if (!dig) begin
                    emit     = 1'b1;
                    fin_kind = c_kind;
                    fin_trim = 3'd2;
                end else begin
                    fall_expdig = 1'b1;
                end
            end
            PH_EXPDIG: begin
                if (dig) begin
                    fall_expdig = 1'b1;
                end else begin
                    emit     = 1'b1;
                    fin_kind = c_kind;
                end
            end
            default: begin
            end
        endcase

        if (fall_signed) begin
            if (lc == CH_LO_I) begin
                n_phase    = PH_INF;
                n_kp       = 3'd0;
                do_consume = 1'b1;
            end else if (dig) begin
                do_int     = 1'b1;
                n_phase    = PH_INT;
                do_consume = 1'b1;
            end else if (ch == CH_POINT) begin
                n_phase    = PH_FRAC;
                do_consume = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        if (fall_expdig) begin
            do_exp     = 1'b1;
            n_phase    = PH_EXPDIG;
            do_consume = 1'b1;
        end

        if (do_int || do_frac) begin
            n_kind = KIND_NUMBER;
        end
        if (do_int && c_count >= COUNT_W'(MAX_DIGITS) && c_ps > SHIFT_MIN) begin
            // digits past the limit only scale the value
            n_ps = c_ps - SHIFT_W'(1);
        end
        if (do_frac && c_count < COUNT_W'(MAX_DIGITS) && c_ps < SHIFT_MAX) begin
            n_ps = c_ps + SHIFT_W'(1);
        end
        if ((do_int || do_frac) && c_count < COUNT_W'(MAX_DIGITS)
                && (c_count != '0 || dval != 4'd0)) begin
            n_digits[c_count[DIGIT_IDX_W-1:0]] = dval;
            n_count = c_count + COUNT_W'(1);
        end

        if (do_exp) begin
            acc10 = {c_acc, 3'b000} + {2'b00, c_acc, 1'b0} + (ACC_W+4)'(dval);
            n_acc = (acc10 > (ACC_W+4)'(ACC_LIMIT)) ? ACC_LIMIT : acc10[ACC_W-1:0];
        end

        if (do_consume && c_len != LEN_MAX) begin
            n_len = c_len + LENGTH_BITS'(1);
        end

        if (emit) begin
            n_phase  = PH_IDLE;
            n_kp     = 3'd0;
            n_sign   = 1'b0;
            n_kind   = KIND_NONE;
            n_count  = '0;
            n_ps     = '0;
            n_acc    = '0;
            n_expneg = 1'b0;
            n_len    = '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                n_digits[i] = 4'd0;
            end
        end
    end

    // result fields for the token being closed
    always_comb begin
        logic signed [EXP_W-1:0]  exp_mag;
        logic [LENGTH_BITS-1:0]   len_trim;

        res_neg   = 1'b0;
        res_count = 5'd0;
        res_first = '0;
        res_last  = '0;
        res_exp   = '0;
        res_len   = '0;
        exp_mag   = $signed({2'b00, c_acc});
        len_trim  = (c_len != LEN_MAX) ? c_len - LENGTH_BITS'(fin_trim) : c_len;

        if (fin_kind != KIND_NONE) begin
            res_neg = (fin_kind == KIND_NUMBER || fin_kind == KIND_INF) ? c_sign : 1'b0;
            res_len = OUT_LEN_W'(len_trim);
        end
        if (fin_kind == KIND_NUMBER) begin
            res_count = 5'(c_count);
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (i < 10) begin
                    res_first[BCD_W-1-4*i -: 4] = c_digits[i];
                end else begin
                    res_last[BCD_W-1-4*(i-10) -: 4] = c_digits[i];
                end
            end
            res_exp = (c_expneg ? -exp_mag : exp_mag) - EXP_W'(c_ps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kp     <= 3'd0;
            r_sign   <= 1'b0;
            r_kind   <= KIND_NONE;
            r_count  <= '0;
            r_ps     <= '0;
            r_acc    <= '0;
            r_expneg <= 1'b0;
            r_len    <= '0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_digits[i] <= 4'd0;
            end
        end else if (proc) begin
            r_phase  <= n_phase;
            r_kp     <= n_kp;
            r_sign   <= n_sign;
            r_kind   <= n_kind;
            r_count  <= n_count;
            r_ps     <= n_ps;
            r_acc    <= n_acc;
            r_expneg <= n_expneg;
            r_len    <= n_len;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_digits[i] <= n_digits[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_neg   <= res_neg;
            r_out_kind  <= fin_kind;
            r_out_count <= res_count;
            r_out_first <= res_first;
            r_out_last  <= res_last;
            r_out_exp   <= res_exp;
            r_out_len   <= res_len;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_negative         = r_out_neg;
    assign o_number_kind      = r_out_kind;
    assign o_digit_count      = r_out_count;
    assign o_digits_first_ten = r_out_first;
    assign o_digits_last_ten  = r_out_last;
    assign o_decimal_exponent = r_out_exp;
    assign o_consumed_length  = r_out_len;

endmodule

>>> sv/dfts_checker.sv
// port-level checks for the decimal float text scanner, bound to the top level
module dfts_checker
    import dfts_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic [7:0]              i_char_code,
    input logic                    i_starts_string,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic                    o_negative,
    input logic [1:0]              o_number_kind,
    input logic [4:0]              o_digit_count,
    input logic [BCD_W-1:0]        o_digits_first_ten,
    input logic [BCD_W-1:0]        o_digits_last_ten,
    input logic signed [EXP_W-1:0] o_decimal_exponent,
    input logic [OUT_LEN_W-1:0]    o_consumed_length
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_number_kind)
            && $stable(o_decimal_exponent) && $stable(o_consumed_length)
            && $stable(o_digits_first_ten))
        else $error("result changed while stalled");

    // empty token reports nothing at all
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_number_kind == KIND_NONE |-> !o_negative && o_digit_count == 5'd0
            && o_decimal_exponent == '0 && o_consumed_length == '0)
        else $error("empty token has nonzero fields");

    // keywords carry no digits and no exponent
    a_keyword_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_number_kind == KIND_INF || o_number_kind == KIND_NAN)
            |-> o_digit_count == 5'd0 && o_digits_first_ten == '0
            && o_digits_last_ten == '0 && o_decimal_exponent == '0
            && o_consumed_length != '0)
        else $error("keyword result carries digit fields");

    // nan never gets a sign, and the digit count stays in range
    a_nan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_number_kind != KIND_NAN || !o_negative)
            && o_digit_count <= 5'(MAX_DIGITS))
        else $error("bad sign or digit count");

endmodule

bind decimal_float_text_scanner dfts_checker u_dfts_checker (.*);
